[rtl/sfpp_pkg.sv]
// Shared constants, types and control structs for the spectrum first peak picker.
package sfpp_pkg;

    localparam int NUM_BINS_DEF     = 4096;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int SR_W       = 18;
    localparam int THR_W      = 16;
    localparam int PEAK_BIN_W = 12;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [SR_W-1:0]  SR_RST  = 18'd44100;
    localparam logic [THR_W-1:0] THR_RST = 16'd16384;

    localparam logic REG_FS     = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_DRAIN = 8'b00000010,
        S_PREP  = 8'b00000100,
        S_RD0   = 8'b00001000,
        S_CUR   = 8'b00010000,
        S_RD    = 8'b00100000,
        S_EV    = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    typedef struct packed {
        logic accept;
        logic prep;
        logic rd_first;
        logic cap_cur;
        logic eval;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic last_wr;
        logic stop;
    } t_dp_sts;

endpackage

[rtl/spectrum_first_peak_picker_core.sv]
// Top level of the spectrum first peak picker: configuration registers and core wiring.
//
// channel  | direction | handshake                              | payload
// bins     | in        | start && !busy                         | i_bin_re, i_bin_im, i_last_bin
// result   | out       | o_result_valid, one cycle, no backpress | o_peak_found, o_peak_bin,
//          |           |                                        | o_peak_frequency
// config   | in/out    | psel && penable && pwrite, pready = 1  | 0x0 rate in Hz, 0x4 threshold
//
// Bins are taken one per cycle while busy is low; a bin with i_last_bin raises busy.
// After the last bin, the frame passes the power pipeline, a step that splits the rate and
// forms the threshold product, the priming of the first bin, and a read and an evaluation per
// bin on the single RAM read port up to bin k, where the search stops; then the result strobes.
// busy drops the cycle after the strobe. NUM_BINS must be a power of two; nothing enforces it.
// Reset is synchronous; the bin RAM is never cleared, only bins of the current frame are read.
// The result is shown for one cycle only; the receiver has no way to stall it.
module spectrum_first_peak_picker_core #(
    parameter int NUM_BINS     = sfpp_pkg::NUM_BINS_DEF,
    parameter int SAMPLE_WIDTH = sfpp_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_bin_re,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_bin_im,
    input  logic                                i_last_bin,
    output logic                                o_result_valid,
    output logic                                o_peak_found,
    output logic [sfpp_pkg::PEAK_BIN_W-1:0]     o_peak_bin,
    output logic [sfpp_pkg::SR_W-1:0]           o_peak_frequency,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfpp_pkg::APB_AW-1:0]         paddr,
    input  logic [sfpp_pkg::APB_DW-1:0]         pwdata,
    output logic [sfpp_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import sfpp_pkg::*;

    logic [SR_W-1:0]  r_fs_hz;
    logic [THR_W-1:0] r_thresh;
    logic             w_wr;
    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_hz  <= SR_RST;
            r_thresh <= THR_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_FS: begin
                    r_fs_hz <= pwdata[SR_W-1:0];
                end
                REG_THRESH: begin
                    r_thresh <= pwdata[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FS: begin
                prdata = APB_DW'(r_fs_hz);
            end
            REG_THRESH: begin
                prdata = APB_DW'(r_thresh);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    sfpp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_last_bin     (i_last_bin),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    sfpp_dp #(
        .NUM_BINS     (NUM_BINS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_bin_re         (i_bin_re),
        .i_bin_im         (i_bin_im),
        .i_last_bin       (i_last_bin),
        .i_fs_hz          (r_fs_hz),
        .i_thresh         (r_thresh),
        .o_peak_found     (o_peak_found),
        .o_peak_bin       (o_peak_bin),
        .o_peak_frequency (o_peak_frequency)
    );

endmodule

[rtl/sfpp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfpp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/sfpp_ctrl.sv]
// Controller state machine: load, drain and bin search sequencing.
module sfpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last_bin,
    input  sfpp_pkg::t_dp_sts i_sts,
    output sfpp_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_result_valid
);
    import sfpp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_last_bin) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.last_wr) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_RD0;
            end
            S_RD0: begin
                n_state = S_CUR;
            end
            S_CUR: begin
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                n_state = i_sts.stop ? S_DONE : S_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd.accept   = (r_state == S_IDLE) && i_start;
    assign o_cmd.prep     = (r_state == S_PREP);
    assign o_cmd.rd_first = (r_state == S_RD0);
    assign o_cmd.cap_cur  = (r_state == S_CUR);
    assign o_cmd.eval     = (r_state == S_EV);
    assign o_cmd.clear    = (r_state == S_DONE);

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_DONE);

endmodule

[rtl/sfpp_dp.sv]
// Datapath: power pipeline, bin store, maximum, bin frequency step and peak search.
module sfpp_dp #(
    parameter int NUM_BINS     = sfpp_pkg::NUM_BINS_DEF,
    parameter int SAMPLE_WIDTH = sfpp_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfpp_pkg::t_dp_cmd                   i_cmd,
    output sfpp_pkg::t_dp_sts                   o_sts,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_bin_re,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_bin_im,
    input  logic                                i_last_bin,
    input  logic [sfpp_pkg::SR_W-1:0]           i_fs_hz,
    input  logic [sfpp_pkg::THR_W-1:0]          i_thresh,
    output logic                                o_peak_found,
    output logic [sfpp_pkg::PEAK_BIN_W-1:0]     o_peak_bin,
    output logic [sfpp_pkg::SR_W-1:0]           o_peak_frequency
);
    import sfpp_pkg::*;

    localparam int PW  = 2 * SAMPLE_WIDTH;
    localparam int AW  = $clog2(NUM_BINS);
    localparam int CW  = $clog2(NUM_BINS + 1);
    localparam int RW  = AW + 1;
    localparam int TW  = PW + THR_W;
    localparam int KW  = (AW > PEAK_BIN_W) ? AW : PEAK_BIN_W;

    // load pipeline
    logic                           r_a_v;
    logic                           r_a_last;
    logic signed [SAMPLE_WIDTH-1:0] r_re;
    logic signed [SAMPLE_WIDTH-1:0] r_im;
    logic                           r_b_v;
    logic                           r_b_last;
    logic [PW-1:0]                  r_sq_re;
    logic [PW-1:0]                  r_sq_im;
    logic                           r_c_v;
    logic                           r_c_last;
    logic [PW-1:0]                  r_pwr;
    logic [CW-1:0]                  r_count;
    logic [PW-1:0]                  r_max;

    logic signed [PW-1:0] w_sq_re;
    logic signed [PW-1:0] w_sq_im;
    logic                 w_store;

    // search
    logic [TW-1:0]   r_thr;
    logic [AW-1:0]   r_div_rem;
    logic [SR_W-1:0] r_div_q;
    logic [AW-1:0]   r_k;
    logic [SR_W-1:0] r_q;
    logic [AW-1:0]   r_r;
    logic [PW-1:0]   r_cur;
    logic                  r_found;
    logic [PEAK_BIN_W-1:0] r_bin;
    logic [SR_W-1:0]       r_freq;

    logic [RW-1:0]   w_r_sum;
    logic            w_r_wrap;
    logic [AW-1:0]   n_r;
    logic [SR_W-1:0] n_q;
    logic [CW-1:0]   w_k_next;
    logic            w_at_last;
    logic            w_hit;
    logic [KW-1:0]   w_k_ext;
    logic [AW-1:0]   w_rd_addr;
    logic [PW-1:0]   w_rd_data;

    assign w_sq_re = PW'(r_re) * PW'(r_re);
    assign w_sq_im = PW'(r_im) * PW'(r_im);
    assign w_store = r_c_v && (r_count < CW'(NUM_BINS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_count <= '0;
            r_max   <= '0;
        end else begin
            r_a_v <= i_cmd.accept;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            if (i_cmd.clear) begin
                r_count <= '0;
                r_max   <= '0;
            end else if (w_store) begin
                r_count <= r_count + CW'(1);
                if ((r_count != '0) && (r_pwr > r_max)) begin
                    r_max <= r_pwr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_re     <= i_bin_re;
        r_im     <= i_bin_im;
        r_a_last <= i_last_bin;
        r_sq_re  <= $unsigned(w_sq_re);
        r_sq_im  <= $unsigned(w_sq_im);
        r_b_last <= r_a_last;
        r_pwr    <= r_sq_re + r_sq_im;
        r_c_last <= r_b_last;
    end

    // bin store
    assign w_rd_addr = i_cmd.rd_first ? '0 : AW'(w_k_next);

    sfpp_ram #(
        .WIDTH(PW),
        .DEPTH(NUM_BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_pwr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // frequency of bin k tracked as quotient and remainder of fs*k/NUM_BINS
    assign w_r_sum  = RW'(r_r) + RW'(r_div_rem);
    assign w_r_wrap = (w_r_sum >= RW'(NUM_BINS));
    assign n_r      = w_r_wrap ? AW'(w_r_sum - RW'(NUM_BINS)) : AW'(w_r_sum);
    assign n_q      = r_q + r_div_q + SR_W'(w_r_wrap);

    assign w_k_next  = CW'(r_k) + CW'(1);
    assign w_at_last = (w_k_next == r_count);
    assign w_hit     = (r_q != '0)
                    && (w_at_last || (r_cur > w_rd_data))
                    && ({r_cur, {THR_W{1'b0}}} > r_thr);
    assign w_k_ext   = KW'(r_k);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_thr     <= TW'(i_thresh) * TW'(r_max);
            r_div_q   <= i_fs_hz >> AW;
            r_div_rem <= i_fs_hz[AW-1:0];
            r_k       <= '0;
            r_q       <= '0;
            r_r       <= '0;
        end
        if (i_cmd.cap_cur) begin
            r_cur <= w_rd_data;
        end
        if (i_cmd.eval) begin
            if (w_hit || w_at_last) begin
                r_found <= w_hit;
                r_bin   <= w_hit ? w_k_ext[PEAK_BIN_W-1:0] : '0;
                r_freq  <= w_hit ? r_q : '0;
            end else begin
                r_cur <= w_rd_data;
                r_k   <= r_k + AW'(1);
                r_q   <= n_q;
                r_r   <= n_r;
            end
        end
    end

    assign o_sts.last_wr  = r_c_v && r_c_last;
    assign o_sts.stop     = w_hit || w_at_last;

    assign o_peak_found     = r_found;
    assign o_peak_bin       = r_bin;
    assign o_peak_frequency = r_freq;

endmodule

[rtl/sfpp_chk.sv]
// Port-level checker for the spectrum first peak picker, bound to the top level.
module sfpp_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            i_last_bin,
    input logic                            o_result_valid,
    input logic                            o_peak_found,
    input logic [sfpp_pkg::PEAK_BIN_W-1:0] o_peak_bin,
    input logic [sfpp_pkg::SR_W-1:0]       o_peak_frequency
);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");

    a_mid_frame_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_bin) |=> !busy)
        else $error("busy raised by a bin that does not end the frame");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_peak_found) |-> ((o_peak_bin == '0) && (o_peak_frequency == '0)))
        else $error("not-found result carries nonzero fields");

    a_found_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_peak_found) |-> (o_peak_frequency != '0))
        else $error("found peak with zero frequency");

endmodule

bind spectrum_first_peak_picker_core sfpp_chk u_chk (.*);
